/* rtl/cdc_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and calendar helper functions for the calendar date counter.
// Used by the channel interfaces and by every module of the block.
package cdc_pkg;

  localparam int YEAR_W     = 14;
  localparam int MONTH_W    = 4;
  localparam int DAY_W      = 5;
  localparam int DIST_W     = 23;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 14;
  localparam int DOY_W      = 9;

  localparam logic [YEAR_W-1:0]  YEAR_TOP    = 14'd9999;
  localparam logic [YEAR_W-1:0]  RESET_YEAR  = 14'd2022;
  localparam logic [MONTH_W-1:0] RESET_MONTH = 4'd3;
  localparam logic [DAY_W-1:0]   RESET_DAY   = 5'd11;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_START_YEAR  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_MONTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_DAY   = 2'd2;

  // Input function codes.
  localparam logic FUNC_ADVANCE = 1'b0;
  localparam logic FUNC_QUERY   = 1'b1;

  // Reciprocals: floor(y * 5243 / 2^17) = floor(y / 25) for any 14-bit y,
  // floor(p * 10486 / 2^20) = floor(p / 100) for p up to 9998.
  localparam int DIV25_MUL   = 5243;
  localparam int DIV25_SHR   = 17;
  localparam int DIV100_MUL  = 10486;
  localparam int DIV100_SHR  = 20;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } date_t;

  // A year divisible by 100 is leap only when it is also divisible by 400,
  // which for a multiple of 25 means divisible by 16.
  function automatic logic leap_year(input logic [YEAR_W-1:0] y);
    logic [26:0]        prod;
    logic [9:0]         q;
    logic [YEAR_W-1:0]  r;
    prod = 27'(y) * 27'(DIV25_MUL);
    q = prod[26:DIV25_SHR];
    r = y - (14'(q) * 14'd25);
    if (r == '0) begin
      leap_year = (y[3:0] == 4'd0);
    end else begin
      leap_year = (y[1:0] == 2'd0);
    end
  endfunction

  // Month length; a month outside 1..12 counts as 31 days.
  function automatic logic [DAY_W-1:0] month_len(input logic [YEAR_W-1:0] y,
                                                 input logic [MONTH_W-1:0] m);
    case (m)
      4'd2: begin
        month_len = leap_year(y) ? 5'd29 : 5'd28;
      end
      4'd4, 4'd6, 4'd9, 4'd11: begin
        month_len = 5'd30;
      end
      default: begin
        month_len = 5'd31;
      end
    endcase
  endfunction

  function automatic logic [DOY_W-1:0] days_before(input logic [MONTH_W-1:0] m);
    case (m)
      4'd2:    days_before = 9'd31;
      4'd3:    days_before = 9'd59;
      4'd4:    days_before = 9'd90;
      4'd5:    days_before = 9'd120;
      4'd6:    days_before = 9'd151;
      4'd7:    days_before = 9'd181;
      4'd8:    days_before = 9'd212;
      4'd9:    days_before = 9'd243;
      4'd10:   days_before = 9'd273;
      4'd11:   days_before = 9'd304;
      4'd12:   days_before = 9'd334;
      default: days_before = 9'd0;
    endcase
  endfunction

endpackage

/* rtl/cdc_in_if.sv */
`timescale 1ns / 1ps
// Input channel of the calendar date counter: valid/ready plus one item.
// Depends on cdc_pkg for field widths.
interface cdc_in_if;
  logic                          valid;
  logic                          ready;
  logic                          func;
  logic [cdc_pkg::YEAR_W-1:0]    query_year;
  logic [cdc_pkg::MONTH_W-1:0]   query_month;
  logic [cdc_pkg::DAY_W-1:0]     query_day;

  modport source (output valid, func, query_year, query_month, query_day, input ready);
  modport sink   (input valid, func, query_year, query_month, query_day, output ready);
endinterface

/* rtl/cdc_out_if.sv */
`timescale 1ns / 1ps
// Result channel of the calendar date counter: valid/ready plus one result item.
// Depends on cdc_pkg for field widths.
interface cdc_out_if;
  logic                               valid;
  logic                               ready;
  logic [cdc_pkg::YEAR_W-1:0]         date_year;
  logic [cdc_pkg::MONTH_W-1:0]        date_month;
  logic [cdc_pkg::DAY_W-1:0]          date_day;
  logic signed [cdc_pkg::DIST_W-1:0]  days_between;

  modport source (output valid, date_year, date_month, date_day, days_between, input ready);
  modport sink   (input valid, date_year, date_month, date_day, days_between, output ready);
endinterface

/* rtl/cdc_date_state.sv */
`timescale 1ns / 1ps
// Current-date register with configuration load and one-day advance logic.
// Depends on cdc_pkg.
module cdc_date_state (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [cdc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cdc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           adv,
  output cdc_pkg::date_t                 cur,
  output cdc_pkg::date_t                 cur_nxt
);
  import cdc_pkg::*;

  date_t             cur_r;
  date_t             date_nxt;
  logic [DAY_W-1:0]  len;

  assign len = month_len(cur_r.year, cur_r.month);

  always_comb begin
    date_nxt = cur_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_START_YEAR:  date_nxt.year  = cfg_data[YEAR_W-1:0];
        CFG_START_MONTH: date_nxt.month = cfg_data[MONTH_W-1:0];
        CFG_START_DAY:   date_nxt.day   = cfg_data[DAY_W-1:0];
        default:         date_nxt = cur_r;
      endcase
    end else if (adv) begin
      if (cur_r.day >= len) begin
        if (cur_r.month >= 4'd12) begin
          // At YEAR_TOP (9999) or any later year the date saturates.
          if (cur_r.year < YEAR_TOP) begin
            date_nxt.year  = cur_r.year + 14'd1;
            date_nxt.month = 4'd1;
            date_nxt.day   = 5'd1;
          end
        end else begin
          date_nxt.month = cur_r.month + 4'd1;
          date_nxt.day   = 5'd1;
        end
      end else begin
        date_nxt.day = cur_r.day + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r <= '{year: RESET_YEAR, month: RESET_MONTH, day: RESET_DAY};
    end else begin
      cur_r <= date_nxt;
    end
  end

  assign cur     = cur_r;
  assign cur_nxt = date_nxt;

  a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (!cfg_we && !adv) |=> $stable(cur_r))
    else $error("current date changed without an advance or a write");

  a_advance_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && !cfg_we && cur_r.year < YEAR_TOP) |=> (cur_r != $past(cur_r)))
    else $error("advance below the top year left the date unchanged");

  a_month_load: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_we && cfg_index == CFG_START_MONTH) |=>
      (cur_r.month == $past(cfg_data[MONTH_W-1:0])))
    else $error("month write not loaded");

endmodule

/* rtl/cdc_day_num.sv */
`timescale 1ns / 1ps
// Two-stage day-number unit: converts a date to days counted from 0001-01-01.
// Depends on cdc_pkg; the result is kept modulo 2^DIST_W.
module cdc_day_num (
  input  logic                        clk,
  input  logic                        en_a,
  input  logic                        en_b,
  input  cdc_pkg::date_t              date,
  output logic [cdc_pkg::DIST_W-1:0]  num
);
  import cdc_pkg::*;

  logic [YEAR_W-1:0]   yc;
  logic [MONTH_W-1:0]  mc;
  logic [YEAR_W-1:0]   p;
  logic [27:0]         p_div_prod;
  logic [DOY_W:0]      doy;

  logic [DIST_W-1:0]   p365_r;
  logic [YEAR_W-3:0]   p4_r;
  logic [6:0]          q100_r;
  logic [DOY_W:0]      doy_r;
  logic [DIST_W-1:0]   num_r;

  // Out-of-range year and month are clamped; the day is used as given.
  always_comb begin
    if (date.year == '0) begin
      yc = 14'd1;
    end else if (date.year > YEAR_TOP) begin
      yc = YEAR_TOP;
    end else begin
      yc = date.year;
    end
    if (date.month == '0) begin
      mc = 4'd1;
    end else if (date.month > 4'd12) begin
      mc = 4'd12;
    end else begin
      mc = date.month;
    end
    p          = yc - 14'd1;
    p_div_prod = 28'(p) * 28'(DIV100_MUL);
    doy        = 10'(days_before(mc)) + 10'((mc > 4'd2) && leap_year(yc)) + 10'(date.day);
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      p365_r <= 23'(p) * 23'd365;
      p4_r   <= p[YEAR_W-1:2];
      q100_r <= p_div_prod[DIV100_SHR+6:DIV100_SHR];
      doy_r  <= doy;
    end
  end

  // floor(p/400) is floor(floor(p/100)/4).
  always_ff @(posedge clk) begin
    if (en_b) begin
      num_r <= p365_r + 23'(p4_r) + 23'(q100_r[6:2]) + 23'(doy_r)
               - 23'(q100_r) - 23'd1;
    end
  end

  assign num = num_r;

endmodule

/* rtl/calendar_date_counter.sv */
`timescale 1ns / 1ps
// Calendar date counter: keeps a Gregorian current date and measures day distances.
// Depends on cdc_pkg, cdc_in_if, cdc_out_if, cdc_date_state and cdc_day_num.
//
// Usage:
//   in_ch   valid/ready channel; func 0 advances the current date one day,
//           func 1 asks for query date minus current date in days.
//   out_ch  one result item per input item, in order: the current date after
//           the item and days_between (zero for an advance).
//   cfg_*   write port; index 0/1/2 loads year/month/day of the current date
//           at once. Write only while no item is in flight.
// Timing: the current date is updated at the edge that accepts an item, so
//   items may follow each other every cycle while in_ch is ready. A result
//   reaches out_ch through the four-register pipeline of the block (input,
//   partial terms in the day-number units, day numbers, result).
//   Throughput is one item per cycle while out_ch is ready.
// Reset: the current date becomes 2022-03-11 and the pipeline empties.
// Stall: while out_ch is not ready the result register holds; earlier stages
//   keep filling and in_ch ready drops only once every stage is occupied.
module calendar_date_counter (
  input  logic                           clk,
  input  logic                           rst_n,
  cdc_in_if.sink                         in_ch,
  cdc_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [cdc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cdc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import cdc_pkg::*;

  date_t              cur;
  date_t              cur_nxt;
  logic               in_acc;
  logic               rdy1, rdy2, rdy3, rdy4;

  logic               v1_r, v2_r, v3_r, v4_r;
  logic               v1_nxt, v2_nxt, v3_nxt, v4_nxt;

  logic               s1_func_r;
  date_t              s1_cur_r;
  date_t              s1_qry_r;
  logic               s2_func_r;
  date_t              s2_cur_r;
  logic               s3_func_r;
  date_t              s3_cur_r;
  logic               s4_func_r;
  date_t              s4_cur_r;
  logic [DIST_W-1:0]  s4_dist_r;

  logic [DIST_W-1:0]  num_q;
  logic [DIST_W-1:0]  num_c;

  // A stage takes new data when it is empty or its content moves on.
  assign rdy4        = !v4_r || out_ch.ready;
  assign rdy3        = !v3_r || rdy4;
  assign rdy2        = !v2_r || rdy3;
  assign rdy1        = !v1_r || rdy2;
  assign in_ch.ready = rdy1;
  assign in_acc      = in_ch.valid && rdy1;

  cdc_date_state u_state (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .adv       (in_acc && (in_ch.func == FUNC_ADVANCE)),
    .cur       (cur),
    .cur_nxt   (cur_nxt)
  );

  always_comb begin
    v1_nxt = rdy1 ? in_acc : v1_r;
    v2_nxt = rdy2 ? v1_r   : v2_r;
    v3_nxt = rdy3 ? v2_r   : v3_r;
    v4_nxt = rdy4 ? v3_r   : v4_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
      v4_r <= v4_nxt;
    end
  end

  // The date after the item travels with it down the pipeline.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_func_r <= in_ch.func;
      s1_cur_r  <= cur_nxt;
      s1_qry_r  <= '{year: in_ch.query_year, month: in_ch.query_month,
                     day: in_ch.query_day};
    end
    if (rdy2) begin
      s2_func_r <= s1_func_r;
      s2_cur_r  <= s1_cur_r;
    end
    if (rdy3) begin
      s3_func_r <= s2_func_r;
      s3_cur_r  <= s2_cur_r;
    end
    if (rdy4) begin
      s4_func_r <= s3_func_r;
      s4_cur_r  <= s3_cur_r;
      s4_dist_r <= (s3_func_r == FUNC_QUERY) ? (num_q - num_c) : '0;
    end
  end

  cdc_day_num u_num_qry (
    .clk  (clk),
    .en_a (rdy2),
    .en_b (rdy3),
    .date (s1_qry_r),
    .num  (num_q)
  );

  cdc_day_num u_num_cur (
    .clk  (clk),
    .en_a (rdy2),
    .en_b (rdy3),
    .date (s1_cur_r),
    .num  (num_c)
  );

  assign out_ch.valid        = v4_r;
  assign out_ch.date_year    = s4_cur_r.year;
  assign out_ch.date_month   = s4_cur_r.month;
  assign out_ch.date_day     = s4_cur_r.day;
  assign out_ch.days_between = $signed(s4_dist_r);

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> v1_r)
    else $error("accepted item did not enter the first stage");

  a_stall_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && v4_r && !out_ch.ready) |=> (v3_r && v4_r))
    else $error("item dropped behind a stalled result");

  a_advance_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (v4_r && s4_func_r == FUNC_ADVANCE) |-> (s4_dist_r == '0))
    else $error("advance result carries a nonzero distance");

  a_query_keeps_date: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.func == FUNC_QUERY && !cfg_we) |=> (cur == $past(cur)))
    else $error("distance query changed the current date");

endmodule

/* tb/calendar_date_counter_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for calendar_date_counter: day advances and day-distance queries.
// Depends on cdc_pkg, cdc_in_if, cdc_out_if and the calendar_date_counter RTL.
module calendar_date_counter_test;
  import cdc_pkg::*;

  localparam int RUN_LIMIT    = 400000;
  localparam int RANDOM_ITEMS = 850;
  localparam int LONG_HOLD    = 80;

  typedef struct {
    logic [YEAR_W-1:0]         year;
    logic [MONTH_W-1:0]        month;
    logic [DAY_W-1:0]          day;
    logic signed [DIST_W-1:0]  days_between;
  } date_report_t;

  // Tracks the current date and holds the reports still owed by the block.
  class date_scoreboard;
    logic [YEAR_W-1:0]  cur_year;
    logic [MONTH_W-1:0] cur_month;
    logic [DAY_W-1:0]   cur_day;
    date_report_t       owed_reports[$];
    int                 errors;

    function new();
      errors = 0;
      reset_date();
    endfunction

    function void reset_date();
      cur_year  = RESET_YEAR;
      cur_month = RESET_MONTH;
      cur_day   = RESET_DAY;
    endfunction

    function bit leap_rule(int y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function int span_of_month(int y, int m);
      if (m < 1 || m > 12) return 31;
      if (m == 2) return leap_rule(y) ? 29 : 28;
      if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
      return 31;
    endfunction

    function int days_ahead_of_month(int m);
      case (m)
        2: return 31;
        3: return 59;
        4: return 90;
        5: return 120;
        6: return 151;
        7: return 181;
        8: return 212;
        9: return 243;
        10: return 273;
        11: return 304;
        12: return 334;
        default: return 0;
      endcase
    endfunction

    // Days since 0001-01-01; year and month are clamped, the day is taken as it is.
    function int ordinal_day(int y, int m, int d);
      int p;
      int n;
      if (y < 1) y = 1;
      if (y > 9999) y = 9999;
      if (m < 1) m = 1;
      if (m > 12) m = 12;
      p = y - 1;
      n = p * 365 + p / 4 - p / 100 + p / 400 + days_ahead_of_month(m);
      if (m > 2 && leap_rule(y)) n = n + 1;
      return n + d - 1;
    endfunction

    function void roll_one_day();
      if (int'(cur_day) >= span_of_month(int'(cur_year), int'(cur_month))) begin
        if (cur_month >= 4'd12) begin
          // The last day of year 9999 (or any later year) is held.
          if (cur_year >= YEAR_TOP) return;
          cur_year  = cur_year + 1'b1;
          cur_month = 4'd1;
          cur_day   = 5'd1;
        end else begin
          cur_month = cur_month + 1'b1;
          cur_day   = 5'd1;
        end
      end else begin
        cur_day = cur_day + 1'b1;
      end
    endfunction

    function void load_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_START_YEAR: cur_year = data[YEAR_W-1:0];
        CFG_START_MONTH: cur_month = data[MONTH_W-1:0];
        CFG_START_DAY: cur_day = data[DAY_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_item(logic func, logic [YEAR_W-1:0] qy, logic [MONTH_W-1:0] qm,
                            logic [DAY_W-1:0] qd);
      date_report_t rep;
      int gap_days;
      gap_days = 0;
      if (func == FUNC_ADVANCE) begin
        roll_one_day();
      end else begin
        gap_days = ordinal_day(int'(qy), int'(qm), int'(qd))
                   - ordinal_day(int'(cur_year), int'(cur_month), int'(cur_day));
      end
      rep.year         = cur_year;
      rep.month        = cur_month;
      rep.day          = cur_day;
      rep.days_between = DIST_W'(gap_days);
      owed_reports.push_back(rep);
    endfunction

    function void check_result(logic [YEAR_W-1:0] y, logic [MONTH_W-1:0] m,
                               logic [DAY_W-1:0] d, logic signed [DIST_W-1:0] days_gap);
      date_report_t rep;
      if (owed_reports.size() == 0) begin
        $error("unexpected result item: %0d-%0d-%0d days_between %0d", y, m, d, days_gap);
        errors++;
        return;
      end
      rep = owed_reports.pop_front();
      if (y !== rep.year) begin
        $error("date_year: expected %0d, actual %0d", rep.year, y);
        errors++;
      end
      if (m !== rep.month) begin
        $error("date_month: expected %0d, actual %0d", rep.month, m);
        errors++;
      end
      if (d !== rep.day) begin
        $error("date_day: expected %0d, actual %0d", rep.day, d);
        errors++;
      end
      if (days_gap !== rep.days_between) begin
        $error("days_between: expected %0d, actual %0d", rep.days_between, days_gap);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  cdc_in_if  in_ch();
  cdc_out_if out_ch();

  date_scoreboard sb;
  int  accepted_items;
  bit  long_hold_done;

  calendar_date_counter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Mostly back to back, sometimes a short pause, now and then a long one.
  function automatic int pick_gap(bit steady);
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  task automatic send_item(int gap, logic func, logic [YEAR_W-1:0] qy,
                           logic [MONTH_W-1:0] qm, logic [DAY_W-1:0] qd);
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid       = 1'b1;
    in_ch.func        = func;
    in_ch.query_year  = qy;
    in_ch.query_month = qm;
    in_ch.query_day   = qd;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.note_item(func, qy, qm, qd);
    accepted_items++;
  endtask

  task automatic advance_day(int gap);
    send_item(gap, FUNC_ADVANCE, YEAR_W'($urandom_range(0, 16383)),
              MONTH_W'($urandom_range(0, 15)), DAY_W'($urandom_range(0, 31)));
  endtask

  task automatic query_date(int gap, int y, int m, int d);
    send_item(gap, FUNC_QUERY, YEAR_W'(y), MONTH_W'(m), DAY_W'(d));
  endtask

  task automatic stop_sending();
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  // Configuration is only touched with nothing in flight.
  task automatic wait_idle();
    while (sb.owed_reports.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    sb.load_reg(idx, data);
  endtask

  task automatic release_cfg();
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Upper data bits above each field are random; only the field width counts.
  task automatic set_date(int y, int m, int d);
    wait_idle();
    write_reg(CFG_START_YEAR, CFG_DATA_W'(y));
    write_reg(CFG_START_MONTH, {10'($urandom), 4'(m)});
    write_reg(CFG_START_DAY, {9'($urandom), 5'(d)});
    release_cfg();
  endtask

  task automatic pick_setting();
    int r;
    int y;
    int m;
    int d;
    r = $urandom_range(0, 99);
    y = $urandom_range(1, 9999);
    m = $urandom_range(1, 12);
    d = $urandom_range(1, sb.span_of_month(y, m));
    if (r < 45) begin
      set_date(y, m, d);
    end else if (r < 65) begin
      if ($urandom_range(0, 1)) m = 12;
      set_date(y, m, sb.span_of_month(y, m) - $urandom_range(0, 2));
    end else if (r < 75) begin
      set_date(9999 - $urandom_range(0, 1), 12, $urandom_range(20, 31));
    end else if (r < 87) begin
      set_date($urandom_range(0, 16383), $urandom_range(0, 15), $urandom_range(0, 31));
    end else begin
      wait_idle();
      case ($urandom_range(0, 2))
        0: write_reg(CFG_START_YEAR, CFG_DATA_W'($urandom_range(0, 16383)));
        1: write_reg(CFG_START_MONTH, CFG_DATA_W'($urandom_range(0, 16383)));
        default: write_reg(CFG_START_DAY, CFG_DATA_W'($urandom_range(0, 16383)));
      endcase
      release_cfg();
    end
  endtask

  task automatic random_item(bit steady);
    int r;
    int y;
    int m;
    int d;
    r = $urandom_range(0, 99);
    y = $urandom_range(1, 9999);
    m = $urandom_range(1, 12);
    d = $urandom_range(1, sb.span_of_month(y, m));
    if (r < 55) begin
      advance_day(pick_gap(steady));
    end else if (r < 80) begin
      query_date(pick_gap(steady), y, m, d);
    end else if (r < 90) begin
      query_date(pick_gap(steady), int'(sb.cur_year), $urandom_range(0, 15),
                 $urandom_range(0, 31));
    end else begin
      query_date(pick_gap(steady), $urandom_range(0, 16383), $urandom_range(0, 15),
                 $urandom_range(0, 31));
    end
  endtask

  // Result side: random stalls, quiet windows, and one long hold-off that backs up the block.
  initial begin : result_sink
    int stall_left;
    int cyc;
    int r;
    stall_left   = 0;
    cyc          = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      cyc++;
      if (stall_left > 0) begin
        out_ch.ready = 1'b0;
        stall_left--;
      end else begin
        out_ch.ready = 1'b1;
        r = $urandom_range(0, 99);
        if (!long_hold_done && accepted_items >= 300) begin
          stall_left     = LONG_HOLD;
          long_hold_done = 1'b1;
        end else if ((cyc / 128) % 4 != 3) begin
          if (r < 15) stall_left = $urandom_range(1, 3);
          else if (r < 17) stall_left = $urandom_range(8, 30);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      sb.check_result(out_ch.date_year, out_ch.date_month, out_ch.date_day,
                      out_ch.days_between);
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < RUN_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("calendar_date_counter_test: done, errors");
    $finish;
  end

  initial begin : stimulus
    int burst;
    bit steady;
    sb                = new();
    accepted_items    = 0;
    long_hold_done    = 1'b0;
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = CFG_START_YEAR;
    cfg_data          = '0;
    in_ch.valid       = 1'b0;
    in_ch.func        = FUNC_ADVANCE;
    in_ch.query_year  = '0;
    in_ch.query_month = '0;
    in_ch.query_day   = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part, starting from the reset date.
    query_date(0, 2022, 3, 11);
    query_date(0, 1, 1, 1);
    query_date(0, 9999, 12, 31);
    query_date(1, 0, 0, 0);
    query_date(0, 16383, 15, 31);
    query_date(0, 2000, 2, 29);
    query_date(2, 1900, 3, 1);
    query_date(0, 2024, 13, 5);
    advance_day(0);
    stop_sending();

    set_date(2024, 2, 28);
    advance_day(0);
    advance_day(0);
    stop_sending();
    set_date(1900, 2, 28);
    advance_day(0);
    stop_sending();
    set_date(2000, 2, 28);
    advance_day(0);
    stop_sending();
    set_date(1, 1, 1);
    query_date(0, 9999, 12, 31);
    stop_sending();
    // Last days of the calendar: advancing past the final day holds the date.
    set_date(9999, 12, 30);
    advance_day(0);
    advance_day(0);
    advance_day(0);
    query_date(0, 1, 1, 1);
    stop_sending();
    set_date(16383, 12, 31);
    advance_day(0);
    stop_sending();
    // Year, month and day all zero in the current date.
    set_date(0, 0, 0);
    advance_day(0);
    query_date(0, 1, 1, 1);
    stop_sending();
    set_date(2023, 4, 31);
    advance_day(0);
    stop_sending();
    set_date(2023, 15, 31);
    advance_day(0);
    stop_sending();

    // Random part: a fresh setting, then a burst of items against it.
    while (accepted_items < RANDOM_ITEMS + 25) begin
      pick_setting();
      burst  = $urandom_range(20, 90);
      steady = ($urandom_range(0, 4) == 0);
      repeat (burst) random_item(steady);
      stop_sending();
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (sb.owed_reports.size() != 0) begin
      $error("%0d result items never arrived", sb.owed_reports.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("calendar_date_counter_test: done, clean");
    end else begin
      $display("calendar_date_counter_test: done, errors");
    end
    $finish;
  end

endmodule

/* calendar_date_counter.f */
rtl/cdc_pkg.sv
rtl/cdc_in_if.sv
rtl/cdc_out_if.sv
rtl/cdc_date_state.sv
rtl/cdc_day_num.sv
rtl/calendar_date_counter.sv
tb/calendar_date_counter_test.sv
